[rtl/wmns_pkg.sv]
`default_nettype none

package wmns_pkg;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_GRID_COLS = 1'b0,
        REG_GRID_ROWS = 1'b1
    } reg_idx_t;

    typedef logic signed [2:0]  grad_t;
    typedef logic signed [15:0] q14_t;

    localparam logic [8:0] GRID_RESET = 9'd256;

    // magnitude of the unit vector component along a, b being the other axis
    function automatic logic [15:0] unit_mag(input logic [1:0] a, input logic [1:0] b);
        logic [15:0] m;
        case ({a, b})
            4'h4:    m = 16'd16384;
            4'h5:    m = 16'd11585;
            4'h6:    m = 16'd7327;
            4'h7:    m = 16'd5181;
            4'h8:    m = 16'd16384;
            4'h9:    m = 16'd14654;
            4'hA:    m = 16'd11585;
            4'hB:    m = 16'd9088;
            4'hC:    m = 16'd16384;
            4'hD:    m = 16'd15543;
            4'hE:    m = 16'd13632;
            4'hF:    m = 16'd11585;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/wall_mask_normal_stencil_core.sv]
// Wall mask normal stencil.
// Keeps a grid of one-bit wall marks, one memory word per row. Input beats on
// the s_ channel either load the wall bit of one cell or query one cell; each
// beat gives exactly one result beat on the m_ channel: the negated Prewitt
// gradient of the 3x3 neighbourhood (periodic wrap at the grid in use), the
// unit normal and tangent in Q1.14, the wall bit and a boundary flag. Loads
// and cells outside the grid in use give an all-zero result.
// The cfg_ channel sets grid_cols (index 0) and grid_rows (index 1), is always
// ready and is to be written only while the block is idle (not enforced).
// Operation: the single memory read port delivers one row a cycle, with the
// row registered in the cycle after its address. A query reads three rows and
// then registers its result beat; a load is a read-modify-write of one row,
// its result registered as the row is written back; a cell outside the grid
// registers its zero result directly. One item is in flight at a time: the
// next beat is accepted only once the result of the last has been registered.
// A result waits in the output register while the receiver stalls; the next
// beat is still accepted and worked on, and only its final step waits.
// Reset clears control state and sets both grid sizes to 256; the wall
// memory is not cleared and no cell may be queried before it is loaded.
`default_nettype none

module wall_mask_normal_stencil_core
    import wmns_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_command,
    input  wire logic [7:0]         s_col,
    input  wire logic [7:0]         s_row,
    input  wire logic               s_wall_bit,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [2:0]       m_grad_x,
    output logic signed [2:0]       m_grad_y,
    output logic signed [15:0]      m_normal_x,
    output logic signed [15:0]      m_normal_y,
    output logic signed [15:0]      m_tangent_x,
    output logic signed [15:0]      m_tangent_y,
    output logic                    m_is_wall_cell,
    output logic                    m_is_boundary
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam logic [8:0] LIM_C = 9'((MAX_COLS > 511) ? 511 : MAX_COLS);
    localparam logic [8:0] LIM_R = 9'((MAX_ROWS > 511) ? 511 : MAX_ROWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_ZERO
    } state_t;

    state_t              state_reg;
    logic [1:0]          cnt_reg;
    logic [8:0]          cols_reg;
    logic [8:0]          rows_reg;
    logic [7:0]          col_reg;
    logic [8:0]          col_prev_reg;
    logic [8:0]          col_next_reg;
    logic [7:0]          row_reg;
    logic [8:0]          row_next_reg;
    logic                wall_bit_reg;
    logic [2:0]          row0_reg;
    logic [2:0]          row1_reg;

    logic                m_valid_reg;
    grad_t               grad_x_reg;
    grad_t               grad_y_reg;
    q14_t                normal_x_reg;
    q14_t                normal_y_reg;
    q14_t                tangent_y_reg;
    logic                wall_reg;
    logic                boundary_reg;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_reg;
    logic                rd_en;
    logic [RW-1:0]       rd_addr;
    logic                wr_en;
    logic [MAX_COLS-1:0] wr_data;

    logic [8:0]          gc;
    logic [8:0]          gr;
    logic                in_range;
    logic [8:0]          in_col_prev;
    logic [8:0]          in_col_next;
    logic [8:0]          in_row_prev;
    logic [8:0]          in_row_next;
    logic                accept;
    logic                out_free;
    logic                emit;
    logic                zero_res;
    logic [2:0]          cur_bits;
    logic [1:0]          left_sum;
    logic [1:0]          right_sum;
    logic [1:0]          top_sum;
    logic [1:0]          bot_sum;
    grad_t               gx;
    grad_t               gy;
    logic [1:0]          ax;
    logic [1:0]          ay;
    q14_t                nx;
    q14_t                ny;
    logic                wall_c;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // effective grid size in use
    always_comb begin
        if (cols_reg == 9'd0) begin
            gc = 9'd1;
        end else if (cols_reg > LIM_C) begin
            gc = LIM_C;
        end else begin
            gc = cols_reg;
        end
        if (rows_reg == 9'd0) begin
            gr = 9'd1;
        end else if (rows_reg > LIM_R) begin
            gr = LIM_R;
        end else begin
            gr = rows_reg;
        end
    end

    assign in_range    = ({1'b0, s_col} < gc) && ({1'b0, s_row} < gr);
    assign in_col_prev = (s_col == 8'd0) ? gc - 9'd1 : {1'b0, s_col} - 9'd1;
    assign in_col_next = ({1'b0, s_col} + 9'd1 == gc) ? 9'd0 : {1'b0, s_col} + 9'd1;
    assign in_row_prev = (s_row == 8'd0) ? gr - 9'd1 : {1'b0, s_row} - 9'd1;
    assign in_row_next = ({1'b0, s_row} + 9'd1 == gr) ? 9'd0 : {1'b0, s_row} + 9'd1;

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = RW'(s_row);
        unique case (state_reg)
            ST_IDLE: begin
                rd_en   = accept && in_range;
                rd_addr = (s_command == CMD_QUERY) ? RW'(in_row_prev) : RW'(s_row);
            end
            ST_READ: begin
                rd_en   = (cnt_reg != 2'd2);
                rd_addr = (cnt_reg == 2'd0) ? RW'(row_reg) : RW'(row_next_reg);
            end
            ST_LOAD, ST_ZERO: begin
                rd_en   = 1'b0;
                rd_addr = RW'(row_reg);
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = RW'(row_reg);
            end
        endcase
    end

    assign wr_en = (state_reg == ST_LOAD);

    always_comb begin
        wr_data                = rd_reg;
        wr_data[CW'(col_reg)]  = wall_bit_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[RW'(row_reg)] <= wr_data;
        end
    end

    // left, centre and right bits of the row word just read
    assign cur_bits = {rd_reg[CW'(col_next_reg)], rd_reg[CW'(col_reg)],
                       rd_reg[CW'(col_prev_reg)]};

    assign left_sum  = {1'b0, row0_reg[0]} + {1'b0, row1_reg[0]} + {1'b0, cur_bits[0]};
    assign right_sum = {1'b0, row0_reg[2]} + {1'b0, row1_reg[2]} + {1'b0, cur_bits[2]};
    assign top_sum   = {1'b0, row0_reg[0]} + {1'b0, row0_reg[1]} + {1'b0, row0_reg[2]};
    assign bot_sum   = {1'b0, cur_bits[0]} + {1'b0, cur_bits[1]} + {1'b0, cur_bits[2]};

    assign gx = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
    assign gy = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
    assign ax = gx[2] ? 2'(-gx) : gx[1:0];
    assign ay = gy[2] ? 2'(-gy) : gy[1:0];
    assign nx = gx[2] ? -$signed(unit_mag(ax, ay)) : $signed(unit_mag(ax, ay));
    assign ny = gy[2] ? -$signed(unit_mag(ay, ax)) : $signed(unit_mag(ay, ax));
    assign wall_c = row1_reg[1];

    assign zero_res = (state_reg != ST_READ);
    assign emit     = out_free && ((state_reg == ST_LOAD) || (state_reg == ST_ZERO)
                                   || ((state_reg == ST_READ) && (cnt_reg == 2'd2)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
            cols_reg    <= GRID_RESET;
            rows_reg    <= GRID_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_GRID_COLS: cols_reg <= cfg_data;
                    REG_GRID_ROWS: rows_reg <= cfg_data;
                    default:       cols_reg <= cols_reg;
                endcase
            end

            if (emit) begin
                m_valid_reg   <= 1'b1;
                grad_x_reg    <= zero_res ? grad_t'(0) : gx;
                grad_y_reg    <= zero_res ? grad_t'(0) : gy;
                normal_x_reg  <= zero_res ? q14_t'(0) : nx;
                normal_y_reg  <= zero_res ? q14_t'(0) : ny;
                tangent_y_reg <= zero_res ? q14_t'(0) : -nx;
                wall_reg      <= zero_res ? 1'b0 : wall_c;
                boundary_reg  <= zero_res ? 1'b0
                               : (wall_c && ((gx != grad_t'(0)) || (gy != grad_t'(0))));
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        col_reg      <= s_col;
                        col_prev_reg <= in_col_prev;
                        col_next_reg <= in_col_next;
                        row_reg      <= s_row;
                        row_next_reg <= in_row_next;
                        wall_bit_reg <= s_wall_bit;
                        cnt_reg      <= 2'd0;
                        if (!in_range) begin
                            state_reg <= ST_ZERO;
                        end else if (s_command == CMD_QUERY) begin
                            state_reg <= ST_READ;
                        end else begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_READ: begin
                    if (cnt_reg == 2'd0) begin
                        row0_reg <= cur_bits;
                        cnt_reg  <= 2'd1;
                    end else if (cnt_reg == 2'd1) begin
                        row1_reg <= cur_bits;
                        cnt_reg  <= 2'd2;
                    end else if (emit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LOAD, ST_ZERO: begin
                    if (emit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_grad_x       = grad_x_reg;
    assign m_grad_y       = grad_y_reg;
    assign m_normal_x     = normal_x_reg;
    assign m_normal_y     = normal_y_reg;
    assign m_tangent_x    = normal_y_reg;
    assign m_tangent_y    = tangent_y_reg;
    assign m_is_wall_cell = wall_reg;
    assign m_is_boundary  = boundary_reg;

endmodule

`default_nettype wire

[rtl/wmns_checker.sv]
`default_nettype none

module wmns_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [2:0]  m_grad_x,
    input wire logic signed [2:0]  m_grad_y,
    input wire logic signed [15:0] m_normal_x,
    input wire logic signed [15:0] m_normal_y,
    input wire logic signed [15:0] m_tangent_x,
    input wire logic signed [15:0] m_tangent_y,
    input wire logic               m_is_wall_cell,
    input wire logic               m_is_boundary
);

    // result beat held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_normal_x) && $stable(m_normal_y)
                                && $stable(m_grad_x) && $stable(m_grad_y))
        else $error("result payload changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tangent_x == m_normal_y) && (m_tangent_y == -m_normal_x))
        else $error("tangent is not the rotated normal");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_boundary |-> m_is_wall_cell
                                     && ((m_grad_x != 3'sd0) || (m_grad_y != 3'sd0)))
        else $error("boundary flag without wall cell and gradient");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_grad_x == 3'sd0) && (m_grad_y == 3'sd0)
            |-> (m_normal_x == 16'sd0) && (m_normal_y == 16'sd0))
        else $error("nonzero normal for zero gradient");

endmodule

bind wall_mask_normal_stencil_core wmns_checker u_wmns_checker (.*);

`default_nettype wire
